### rtl/pid_line_follow_drive_defines.svh
// Assertion macros for the line follow drive block.
`ifndef PID_LINE_FOLLOW_DRIVE_DEFINES_SVH
`define PID_LINE_FOLLOW_DRIVE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PLD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define PLD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed during reset");
`else
`define PLD_ASSERT(lbl, clk, rstn, prop)
`define PLD_ASSERT_RST(lbl, clk, prop)
`endif

`endif

### rtl/pld_pkg.sv
package pld_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DRIVE_W = 12;
    localparam int SUM_W = 20;
    localparam int ERR_W = 11;

    localparam logic [30:0] TARGET_RESET = 31'h7FFF_FFFF;
    localparam logic [9:0] THRESHOLD_RESET = 10'd800;
    localparam logic signed [11:0] SPEED_RESET = 12'sd1000;
    localparam logic [15:0] GAIN_P_RESET = 16'd614;
    localparam logic [15:0] GAIN_I_RESET = 16'd26;
    localparam logic [15:0] GAIN_D_RESET = 16'd2099;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DISTANCE  = 3'd0,
        REG_SENSOR_THRESHOLD = 3'd1,
        REG_BASE_SPEED       = 3'd2,
        REG_GAIN_P           = 3'd3,
        REG_GAIN_I           = 3'd4,
        REG_GAIN_D           = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0]        target_distance;
        logic [9:0]         sensor_threshold;
        logic signed [11:0] base_speed;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
    } cfg_t;

    typedef struct packed {
        logic [9:0]         sensor_sample;
        logic signed [31:0] left_ticks;
        logic signed [31:0] right_ticks;
    } item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      reached;
    } result_t;

endpackage

### rtl/pld_cfg.sv
module pld_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [pld_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pld_pkg::CFG_DATA_W-1:0] wr_data,
    output pld_pkg::cfg_t                 cfg
);
    import pld_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_TARGET_DISTANCE:  cfg_next.target_distance = wr_data[30:0];
                REG_SENSOR_THRESHOLD: cfg_next.sensor_threshold = wr_data[9:0];
                REG_BASE_SPEED:       cfg_next.base_speed = $signed(wr_data[11:0]);
                REG_GAIN_P:           cfg_next.gain_p = wr_data[15:0];
                REG_GAIN_I:           cfg_next.gain_i = wr_data[15:0];
                REG_GAIN_D:           cfg_next.gain_d = wr_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_distance <= TARGET_RESET;
            cfg_reg.sensor_threshold <= THRESHOLD_RESET;
            cfg_reg.base_speed <= SPEED_RESET;
            cfg_reg.gain_p <= GAIN_P_RESET;
            cfg_reg.gain_i <= GAIN_I_RESET;
            cfg_reg.gain_d <= GAIN_D_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pld_math.sv
module pld_math (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  pld_pkg::item_t   item,
    input  pld_pkg::cfg_t    cfg,
    output pld_pkg::result_t res
);
    import pld_pkg::*;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ERR_W-1:0] prev_reg;
    logic signed [ERR_W-1:0] prev_next;

    logic signed [31:0]      tgt_s;
    logic                    reached;
    logic signed [ERR_W-1:0] err;
    logic signed [22:0]      seven;
    logic signed [SUM_W-1:0] leak;
    logic signed [SUM_W:0]   isum_w;
    logic signed [SUM_W-1:0] isum;
    logic signed [11:0]      diff;
    logic signed [27:0]      prod_p;
    logic signed [28:0]      prod_d;
    logic signed [36:0]      prod_i;
    logic signed [39:0]      acc;
    logic signed [27:0]      turn;
    logic signed [28:0]      ld_w;
    logic signed [28:0]      rd_w;
    logic signed [DRIVE_W-1:0] ld;
    logic signed [DRIVE_W-1:0] rd;

    always_comb begin
        tgt_s = $signed({1'b0, cfg.target_distance});
        reached = (item.left_ticks >= tgt_s) || (item.right_ticks >= tgt_s);

        err = $signed({1'b0, item.sensor_sample}) - $signed({1'b0, cfg.sensor_threshold});

        // leak by 7/8, truncating toward zero
        seven = (23'(sum_reg) <<< 3) - 23'(sum_reg);
        leak = SUM_W'((seven + (seven[22] ? 23'sd7 : 23'sd0)) >>> 3);
        isum_w = 21'(leak) + (21'(err) <<< 4);
        if (isum_w > 21'sd524287) begin
            isum = 20'sd524287;
        end else if (isum_w < -21'sd524288) begin
            isum = -20'sd524288;
        end else begin
            isum = SUM_W'(isum_w);
        end

        diff = 12'(err) - 12'(prev_reg);

        prod_p = 28'($signed({1'b0, cfg.gain_p})) * 28'(err);
        prod_d = 29'($signed({1'b0, cfg.gain_d})) * 29'(diff);
        prod_i = 37'($signed({1'b0, cfg.gain_i})) * 37'(isum);
        acc = ((40'(prod_p) + 40'(prod_d)) <<< 4) + 40'(prod_i);
        turn = 28'((acc + (acc[39] ? 40'sd4095 : 40'sd0)) >>> 12);

        ld_w = 29'(cfg.base_speed) - 29'(turn);
        rd_w = 29'(cfg.base_speed) + 29'(turn);
        if (ld_w > 29'sd1500) begin
            ld = 12'sd1500;
        end else if (ld_w < -29'sd1500) begin
            ld = -12'sd1500;
        end else begin
            ld = DRIVE_W'(ld_w);
        end
        if (rd_w > 29'sd1500) begin
            rd = 12'sd1500;
        end else if (rd_w < -29'sd1500) begin
            rd = -12'sd1500;
        end else begin
            rd = DRIVE_W'(rd_w);
        end

        // hold state on a reached tick or when not stepping
        sum_next = sum_reg;
        prev_next = prev_reg;
        if (step && !reached) begin
            sum_next = isum;
            prev_next = err;
        end

        res.reached = reached;
        res.left_drive = reached ? '0 : ld;
        res.right_drive = reached ? '0 : rd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            prev_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            prev_reg <= prev_next;
        end
    end

endmodule

### rtl/pid_line_follow_drive.sv
// Channel  Direction  Ports                                               Transfer
// s_       in         s_sensor_sample s_left_ticks s_right_ticks          s_valid && s_ready
// m_       out        m_left_drive m_right_drive m_reached                m_valid && m_ready
// cfg_     in         cfg_index cfg_data                                  cfg_valid && cfg_ready
//
// One item per cycle while m_ready is high; m_valid rises once an item leaves the input register.
// The PID arithmetic runs in one pass between the input register and the result register.
// Reset clears the state, the valid flags and loads the register defaults.
// A stall on m_ready holds the result; the input register still takes one more item.
// cfg_ready is always high.
`include "pid_line_follow_drive_defines.svh"

module pid_line_follow_drive (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [9:0]                     s_sensor_sample,
    input  logic signed [31:0]             s_left_ticks,
    input  logic signed [31:0]             s_right_ticks,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [11:0]             m_left_drive,
    output logic signed [11:0]             m_right_drive,
    output logic                           m_reached,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pld_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pld_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_vld_reg;
    logic    in_vld_next;
    result_t out_reg;
    logic    out_vld_reg;
    logic    out_vld_next;
    result_t res;
    logic    adv;
    logic    s_xfer;
    logic    step;
    logic    drive_in_range;

    assign cfg_ready = 1'b1;

    pld_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pld_math u_math (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        adv = !out_vld_reg || m_ready;
        s_ready = !in_vld_reg || adv;
        s_xfer = s_valid && s_ready;
        step = adv && in_vld_reg;
        in_vld_next = s_xfer ? 1'b1 : (adv ? 1'b0 : in_vld_reg);
        out_vld_next = adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg.sensor_sample <= s_sensor_sample;
            in_reg.left_ticks <= s_left_ticks;
            in_reg.right_ticks <= s_right_ticks;
        end
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_left_drive = out_reg.left_drive;
    assign m_right_drive = out_reg.right_drive;
    assign m_reached = out_reg.reached;

    assign drive_in_range = (m_left_drive <= 12'sd1500) && (m_left_drive >= -12'sd1500)
        && (m_right_drive <= 12'sd1500) && (m_right_drive >= -12'sd1500);

    `PLD_ASSERT(a_reached_zero, aclk, aresetn, m_valid && m_reached |-> {m_left_drive, m_right_drive} == '0)
    `PLD_ASSERT(a_drive_range, aclk, aresetn, m_valid |-> drive_in_range)
    `PLD_ASSERT(a_ready_when_empty, aclk, aresetn, !out_vld_reg |-> s_ready)
    `PLD_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid && !in_vld_reg)

endmodule
